// File: rtl/rva_pkg.sv
// Shared types and constants for the RMS voltage alarm.
`timescale 1ns / 1ps
`default_nettype none
package rva_pkg;

	// APB register file geometry.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes (paddr[3:2]).
	localparam logic [1:0] REG_OFFSET    = 2'd0;
	localparam logic [1:0] REG_GAIN      = 2'd1;
	localparam logic [1:0] REG_MODE      = 2'd2;
	localparam logic [1:0] REG_MANUAL    = 2'd3;

	// Register widths and reset values.
	localparam int OFFSET_W = 12;
	localparam int GAIN_W   = 16;
	localparam int MODE_W   = 2;
	localparam int THR_W    = 8;

	localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd2177;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd12829;
	localparam logic [MODE_W-1:0]   MODE_RST   = 2'd0;
	localparam logic [THR_W-1:0]    MANUAL_RST = 8'd30;

	// Alarm mode codes; the two unused codes (2 and 3) behave as high mode.
	localparam logic [MODE_W-1:0] MODE_LOW    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;

	localparam logic [THR_W-1:0] LOW_THR  = 8'd10;
	localparam logic [THR_W-1:0] HIGH_THR = 8'd30;

	// Datapath widths.
	localparam int SAMPLE_MAX_W = 16;
	localparam int SUM_W        = 33;
	localparam int ROOT_W       = 17;
	localparam int MUL_W        = 17;
	localparam int PROD_W       = 33;
	localparam int TENTHS_W     = 13;
	localparam int VOLTS_W      = 10;

	// Fixed-point scaling: volts = root * gain / 2^21.
	localparam int GAIN_SHIFT = 21;

	// Division of tenths by ten as a reciprocal multiply, exact below 2^13.
	localparam logic [15:0] RECIP_10    = 16'd52429;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [TENTHS_W-1:0] TENTHS_MAX = 13'd8191;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic [OFFSET_W-1:0] sample_offset;
		logic [GAIN_W-1:0]   volt_gain;
		logic [MODE_W-1:0]   alarm_mode;
		logic [THR_W-1:0]    manual_threshold;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/rva_regs.sv
// APB configuration registers of the RMS voltage alarm.
`timescale 1ns / 1ps
`default_nettype none
module rva_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [rva_pkg::ADDR_W-1:0]    paddr,
	input  wire [rva_pkg::DATA_W-1:0]    pwdata,
	output logic [rva_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output rva_pkg::cfg_t                cfg
);
	import rva_pkg::*;

	logic [OFFSET_W-1:0] offset_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [MODE_W-1:0]   mode_q;
	logic [THR_W-1:0]    manual_q;
	logic                wr_en;
	logic [1:0]          reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
			gain_q   <= GAIN_RST;
			mode_q   <= MODE_RST;
			manual_q <= MANUAL_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OFFSET: offset_q <= pwdata[OFFSET_W-1:0];
				REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
				REG_MODE:   mode_q   <= pwdata[MODE_W-1:0];
				REG_MANUAL: manual_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (reg_idx)
			REG_OFFSET: prdata = {{(DATA_W-OFFSET_W){1'b0}}, offset_q};
			REG_GAIN:   prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_q};
			REG_MODE:   prdata = {{(DATA_W-MODE_W){1'b0}}, mode_q};
			REG_MANUAL: prdata = {{(DATA_W-THR_W){1'b0}}, manual_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.sample_offset    = offset_q;
	assign cfg.volt_gain        = gain_q;
	assign cfg.alarm_mode       = mode_q;
	assign cfg.manual_threshold = manual_q;

endmodule
`default_nettype wire

// File: rtl/rva_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rva_sqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [rva_pkg::SUM_W-1:0]     radicand,
	output logic                         done,
	output logic [rva_pkg::ROOT_W-1:0]   root
);
	import rva_pkg::*;

	logic [SUM_W-1:0] rem_q;
	logic [SUM_W:0]   res_q;
	logic [SUM_W-1:0] bit_q;
	logic             run_q;
	logic             done_q;
	logic [SUM_W:0]   trial;
	logic             take;

	// One compare and subtract per cycle.
	assign trial = res_q + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q & bit_q[0];
			if (start) begin
				run_q <= 1'b1;
			end else if (bit_q[0]) begin
				run_q <= 1'b0;
			end
		end
	end

	// Remainder, partial root and the current test bit.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= {1'b1, {(SUM_W-1){1'b0}}};
		end else if (run_q) begin
			if (take) begin
				rem_q <= rem_q - trial[SUM_W-1:0];
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule
`default_nettype wire

// File: rtl/rms_voltage_alarm.sv
// Top level of the true-RMS voltmeter with threshold alarm.
// Usage:
//   Raw ADC words enter on sample with in_valid/in_ready. Each word takes
//   two steps: the zero level is subtracted as it is accepted, then the
//   square passes through the shared multiplier and the saturating add;
//   in_ready stays low until a word is through with both steps.
//   After WINDOW_LEN words one result word leaves on out_valid/out_ready:
//   RMS in tenths and whole volts, alarm flag and the threshold applied.
//   After acceptance the closing word passes through its square, the
//   bit-serial square root and its done flag, then the gain multiply, the
//   scaling by ten, the reciprocal divide by ten and the output load. The
//   square, the gain multiply and the reciprocal divide share the one
//   multiplier. In_ready stays low during that time.
//   The output register holds a result until taken; further samples are
//   accepted meanwhile, and only the next window's result waits for it.
//   Reset clears the sum, the window count and the output valid flag, and
//   loads the register defaults. Registers are written over APB at 4*index.
`timescale 1ns / 1ps
`default_nettype none
module rms_voltage_alarm #(
	parameter int WINDOW_LEN  = 1024,
	parameter int SAMPLE_BITS = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [rva_pkg::ADDR_W-1:0]      paddr,
	input  wire [rva_pkg::DATA_W-1:0]      pwdata,
	output logic [rva_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire [SAMPLE_BITS-1:0]          sample,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [rva_pkg::TENTHS_W-1:0]   rms_tenths,
	output logic [rva_pkg::VOLTS_W-1:0]    rms_volts,
	output logic                           alarm,
	output logic [rva_pkg::THR_W-1:0]      threshold_used
);
	import rva_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_LEN);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN - 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SQ    = 3'd1;
	localparam logic [2:0] ST_ROOT  = 3'd2;
	localparam logic [2:0] ST_GAIN  = 3'd3;
	localparam logic [2:0] ST_SCALE = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	cfg_t                    cfg;
	logic [2:0]              state_q;
	logic [SAMPLE_BITS-1:0]  mag_q;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        count_q;
	logic [PROD_W-1:0]       prod_q;
	logic [TENTHS_W-1:0]     tenths_q;
	logic [VOLTS_W-1:0]      volts_q;
	logic                    out_valid_q;
	logic [TENTHS_W-1:0]     out_tenths_q;
	logic [VOLTS_W-1:0]      out_volts_q;
	logic                    out_alarm_q;
	logic [THR_W-1:0]        out_thr_q;

	logic [SAMPLE_MAX_W-1:0] off_ext;
	logic [SAMPLE_BITS-1:0]  zero_lvl;
	logic [SAMPLE_BITS-1:0]  mag;
	logic [MUL_W-1:0]        mul_a;
	logic [MUL_W-1:0]        mul_b;
	logic [2*MUL_W-1:0]      mul_p;
	logic [SUM_W:0]          sum_add;
	logic [SUM_W-1:0]        sum_sat;
	logic                    root_start;
	logic                    root_done;
	logic [ROOT_W-1:0]       root;
	logic [PROD_W+3:0]       scaled;
	logic [15:0]             tenths_raw;
	logic [THR_W-1:0]        thr;
	logic                    out_free;
	logic                    accept;

	rva_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rva_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sum_sat),
		.done     (root_done),
		.root     (root)
	);

	// Magnitude of the sample relative to the zero level.
	assign off_ext  = {{(SAMPLE_MAX_W-OFFSET_W){1'b0}}, cfg.sample_offset};
	assign zero_lvl = off_ext[SAMPLE_BITS-1:0];
	assign mag      = (sample >= zero_lvl) ? (sample - zero_lvl) : (zero_lvl - sample);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_SQ: begin
				mul_a = {{(MUL_W-SAMPLE_BITS){1'b0}}, mag_q};
				mul_b = {{(MUL_W-SAMPLE_BITS){1'b0}}, mag_q};
			end
			ST_GAIN: begin
				mul_a = root;
				mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg.volt_gain};
			end
			ST_DIV: begin
				mul_a = {{(MUL_W-TENTHS_W){1'b0}}, tenths_q};
				mul_b = {1'b0, RECIP_10};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Saturating accumulation of the squares.
	assign sum_add    = {1'b0, sum_q} + mul_p[SUM_W:0];
	assign sum_sat    = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
	assign root_start = (state_q == ST_SQ) && (count_q == CNT_LAST);

	// Times ten by shift and add, then drop the fraction bits.
	assign scaled     = ({4'b0, prod_q} << 3) + ({4'b0, prod_q} << 1);
	assign tenths_raw = scaled[GAIN_SHIFT+15:GAIN_SHIFT];

	// Threshold for the mode in force when the result is loaded into the output register.
	always_comb begin
		case (cfg.alarm_mode)
			MODE_LOW:    thr = LOW_THR;
			MODE_MANUAL: thr = cfg.manual_threshold;
			default:     thr = HIGH_THR;
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (root_start) begin
						sum_q   <= '0;
						count_q <= '0;
						state_q <= ST_ROOT;
					end else begin
						sum_q   <= sum_sat;
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN:  state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag;
		end
		if (state_q == ST_GAIN) begin
			prod_q <= mul_p[PROD_W-1:0];
		end
		if (state_q == ST_SCALE) begin
			tenths_q <= (|tenths_raw[15:TENTHS_W]) ? TENTHS_MAX : tenths_raw[TENTHS_W-1:0];
		end
		if (state_q == ST_DIV) begin
			volts_q <= mul_p[RECIP_SHIFT+VOLTS_W-1:RECIP_SHIFT];
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_tenths_q <= tenths_q;
			out_volts_q  <= volts_q;
			out_alarm_q  <= ({{(VOLTS_W-THR_W){1'b0}}, thr} < volts_q);
			out_thr_q    <= thr;
		end
	end

	assign out_valid      = out_valid_q;
	assign rms_tenths     = out_tenths_q;
	assign rms_volts      = out_volts_q;
	assign alarm          = out_alarm_q;
	assign threshold_used = out_thr_q;

endmodule
`default_nettype wire
